>>> design/teaching_machine_execute_unit_top_assert.svh
// Assertion macros for the execute unit.
`ifndef TEACHING_MACHINE_EXECUTE_UNIT_TOP_ASSERT_SVH
`define TEACHING_MACHINE_EXECUTE_UNIT_TOP_ASSERT_SVH

`define TMEU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define TMEU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

>>> design/tmeu_pkg.sv
package tmeu_pkg;

  localparam int NUM_REGS   = 16;
  localparam int DATA_WORDS = 1024;
  localparam int WORD_BITS  = 32;

  localparam int RW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int AW    = $clog2(DATA_WORDS);
  localparam int PC_W  = 10;
  localparam int DS_W  = 11;
  localparam int EA_W  = WORD_BITS + 1;

  typedef enum logic [3:0] {
    OP_ILLOP  = 4'd0,
    OP_NOP    = 4'd1,
    OP_LOAD   = 4'd2,
    OP_STORE  = 4'd3,
    OP_ADD    = 4'd4,
    OP_SUB    = 4'd5,
    OP_BRANCH = 4'd6,
    OP_CALL   = 4'd7,
    OP_RET    = 4'd8,
    OP_PUSH   = 4'd9,
    OP_POP    = 4'd10,
    OP_HALT   = 4'd11
  } op_e;

  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_HALT    = 4'd1,
    ST_ILLEGAL = 4'd2,
    ST_IMM     = 4'd3,
    ST_COND    = 4'd4,
    ST_DATA    = 4'd5,
    ST_STACK   = 4'd6,
    ST_UNKNOWN = 4'd7,
    ST_STOPPED = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    CC_ZERO = 2'd0,
    CC_POS  = 2'd1,
    CC_NEG  = 2'd2
  } cond_e;

  typedef enum logic [2:0] {
    CND_NONE = 3'd0,
    CND_EQ   = 3'd1,
    CND_NE   = 3'd2,
    CND_GT   = 3'd3,
    CND_GE   = 3'd4,
    CND_LT   = 3'd5,
    CND_LE   = 3'd6
  } cnd_e;

  localparam int CFG_DATA_SIZE = 0;
  localparam int CFG_DATA_END  = 1;

  typedef struct packed {
    status_e           status;
    logic              taken;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     data_addr;
    logic [PC_W-1:0]   target;
  } dec_t;

endpackage

>>> design/teaching_machine_execute_unit_top.sv
// Execute unit of a small teaching register machine. After reset the unit sweeps the
// 1024-word data memory to zero, one word a cycle, and takes no request until the sweep
// is done; configuration writes are taken at any time. Each request then passes two stages:
// the first reads the register file and checks operands and issues one data memory read,
// the second uses the read word, writes back and loads the result register. Since the next
// request depends on the register file, stack pointer and condition code left behind, a
// request waits in the first stage until the one before it has left the second; a result
// waits in its own register, and the second stage stalls until that result is taken.
module teaching_machine_execute_unit_top
  import tmeu_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [10:0]  cfg_data_i,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [3:0]   operation_i,
  input  logic         immediate_flag_i,
  input  logic         indexed_flag_i,
  input  logic [3:0]   reg_or_cond_i,
  input  logic [31:0]  imm_value_i,
  input  logic [3:0]   index_reg_i,
  input  logic [15:0]  offset_i,
  input  logic [9:0]   abs_address_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [3:0]   status_o,
  output logic [9:0]   instr_addr_o,
  output logic [9:0]   next_pc_o,
  output logic [1:0]   cond_code_o,
  output logic [9:0]   stack_ptr_o,
  output logic [31:0]  written_value_o
);

  localparam int W = WORD_BITS;

  logic [PC_W-1:0] pc_q, pc_d;
  logic [PC_W-1:0] sp_q, sp_d;
  cond_e           cond_q, cond_d;
  logic            stopped_q, stopped_d;
  logic [DS_W-1:0] data_size_q;
  logic [PC_W-1:0] data_end_q;
  logic [AW-1:0]   clr_cnt_q;
  logic            clr_done_q;

  logic            s1_v_q;
  logic [3:0]      s1_op_q;
  logic            s1_imm_q;
  logic            s1_idx_q;
  logic [3:0]      s1_rc_q;
  logic [31:0]     s1_immv_q;
  logic [3:0]      s1_ireg_q;
  logic [15:0]     s1_off_q;
  logic [9:0]      s1_abs_q;

  logic            s2_v_q;
  logic [3:0]      s2_op_q;
  logic            s2_imm_q;
  logic [RW-1:0]   s2_rc_q;
  logic [W-1:0]    s2_rcval_q;
  logic [W-1:0]    s2_immw_q;
  dec_t            s2_dec_q;

  logic            out_valid_q;
  logic [3:0]      status_q;
  logic [PC_W-1:0] instr_addr_q;
  logic [PC_W-1:0] next_pc_q;
  logic [1:0]      cond_code_q;
  logic [PC_W-1:0] stack_ptr_q;
  logic [31:0]     wv_q;

  logic [W-1:0]    rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld_q;
  logic [W-1:0]    rda_q, rdb_q;
  logic [RW-1:0]   ra_a, ra_b;
  logic            rf_we;
  logic [RW-1:0]   rf_wa;
  logic [W-1:0]    rf_wd;

  logic [W-1:0]    dm_mem [DATA_WORDS];
  logic [W-1:0]    dm_rd_q;
  logic            dm_we;
  logic [AW-1:0]   dm_wa;
  logic [W-1:0]    dm_wd;
  logic            ex_we;
  logic [AW-1:0]   ex_wa;
  logic [W-1:0]    ex_wd;

  logic            in_acc;
  logic            adv;
  logic            ex;
  dec_t            dec;
  logic            ok;
  logic            is_ari;
  logic [W-1:0]    src;
  logic [W-1:0]    val;
  logic [PC_W-1:0] pc_adv;
  logic [W-1:0]    wv;

  assign cfg_ready_o = 1'b1;
  assign adv         = s1_v_q && !s2_v_q;
  assign in_ready_o  = clr_done_q && (!s1_v_q || adv);
  assign in_acc      = in_valid_i && in_ready_o;
  assign ex          = s2_v_q && (!out_valid_q || out_ready_i);

  assign ra_a = in_acc ? reg_or_cond_i[RW-1:0] : s1_rc_q[RW-1:0];
  assign ra_b = in_acc ? index_reg_i[RW-1:0] : s1_ireg_q[RW-1:0];

  tmeu_decode u_decode (
    .operation_i      (s1_op_q),
    .immediate_flag_i (s1_imm_q),
    .indexed_flag_i   (s1_idx_q),
    .reg_or_cond_i    (s1_rc_q),
    .index_reg_i      (s1_ireg_q),
    .offset_i         (s1_off_q),
    .abs_address_i    (s1_abs_q),
    .base_i           (rdb_q),
    .sp_i             (sp_q),
    .cond_i           (cond_q),
    .stopped_i        (stopped_q),
    .data_size_i      (data_size_q),
    .data_end_i       (data_end_q),
    .dec_o            (dec)
  );

  always_comb begin
    ok     = (s2_dec_q.status == ST_OK);
    is_ari = (s2_op_q == OP_LOAD) || (s2_op_q == OP_ADD) || (s2_op_q == OP_SUB);
    src    = s2_imm_q ? s2_immw_q : dm_rd_q;
    unique case (s2_op_q)
      OP_ADD:  val = s2_rcval_q + src;
      OP_SUB:  val = s2_rcval_q - src;
      default: val = src;
    endcase
    pc_adv    = pc_q + 1'b1;
    pc_d      = pc_q;
    sp_d      = sp_q;
    cond_d    = cond_q;
    stopped_d = stopped_q || (s2_dec_q.status != ST_OK);
    rf_we     = 1'b0;
    rf_wa     = s2_rc_q;
    rf_wd     = val;
    ex_we     = 1'b0;
    ex_wa     = sp_q[AW-1:0];
    ex_wd     = src;
    wv        = '0;
    if (s2_dec_q.status != ST_STOPPED) begin
      pc_d = pc_adv;
    end
    if (ok) begin
      if (is_ari) begin
        rf_we  = 1'b1;
        wv     = val;
        if (val == '0) begin
          cond_d = CC_ZERO;
        end else if (val[W-1]) begin
          cond_d = CC_NEG;
        end else begin
          cond_d = CC_POS;
        end
      end
      unique case (s2_op_q)
        OP_STORE: begin
          ex_we = 1'b1;
          ex_wa = s2_dec_q.data_addr;
          ex_wd = s2_rcval_q;
          wv    = s2_rcval_q;
        end
        OP_BRANCH: begin
          if (s2_dec_q.taken) begin
            pc_d = s2_dec_q.target;
          end
        end
        OP_CALL: begin
          if (s2_dec_q.taken) begin
            pc_d  = s2_dec_q.target;
            ex_we = 1'b1;
            ex_wd = W'(pc_adv);
            wv    = W'(pc_adv);
            sp_d  = sp_q - 1'b1;
          end
        end
        OP_RET: begin
          pc_d = dm_rd_q[PC_W-1:0];
          sp_d = sp_q + 1'b1;
        end
        OP_PUSH: begin
          ex_we = 1'b1;
          wv    = src;
          sp_d  = sp_q - 1'b1;
        end
        OP_POP: begin
          ex_we = 1'b1;
          ex_wa = s2_dec_q.data_addr;
          ex_wd = dm_rd_q;
          wv    = dm_rd_q;
          sp_d  = sp_q + 1'b1;
        end
        default: begin
        end
      endcase
    end
    dm_we = (!clr_done_q) || (ex && ex_we);
    dm_wa = clr_done_q ? ex_wa : clr_cnt_q;
    dm_wd = clr_done_q ? ex_wd : '0;
  end

  always_ff @(posedge clk_i) begin
    if (ex && rf_we) begin
      rf_mem[rf_wa] <= rf_wd;
    end
    rda_q <= (ex && rf_we && (rf_wa == ra_a)) ? rf_wd
           : (rf_vld_q[ra_a] ? rf_mem[ra_a] : '0);
    rdb_q <= (ex && rf_we && (rf_wa == ra_b)) ? rf_wd
           : (rf_vld_q[ra_b] ? rf_mem[ra_b] : '0);
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dm_mem[dm_wa] <= dm_wd;
    end
    if (adv) begin
      dm_rd_q <= dm_mem[dec.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q    <= '0;
      pc_q        <= '0;
      sp_q        <= PC_W'(DATA_WORDS - 1);
      cond_q      <= CC_ZERO;
      stopped_q   <= 1'b0;
      data_size_q <= DS_W'(1024);
      data_end_q  <= '0;
      clr_cnt_q   <= '0;
      clr_done_q  <= 1'b0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!clr_done_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(DATA_WORDS - 1)) begin
          clr_done_q <= 1'b1;
        end
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == 1'(CFG_DATA_SIZE)) begin
          data_size_q <= cfg_data_i;
        end else begin
          data_end_q <= cfg_data_i[PC_W-1:0];
        end
      end
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (adv) begin
        s1_v_q <= 1'b0;
      end
      if (adv) begin
        s2_v_q <= 1'b1;
      end else if (ex) begin
        s2_v_q <= 1'b0;
      end
      if (ex) begin
        out_valid_q <= 1'b1;
        pc_q        <= pc_d;
        sp_q        <= sp_d;
        cond_q      <= cond_d;
        stopped_q   <= stopped_d;
        if (rf_we) begin
          rf_vld_q[rf_wa] <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q   <= operation_i;
      s1_imm_q  <= immediate_flag_i;
      s1_idx_q  <= indexed_flag_i;
      s1_rc_q   <= reg_or_cond_i;
      s1_immv_q <= imm_value_i;
      s1_ireg_q <= index_reg_i;
      s1_off_q  <= offset_i;
      s1_abs_q  <= abs_address_i;
    end
    if (adv) begin
      s2_op_q    <= s1_op_q;
      s2_imm_q   <= s1_imm_q;
      s2_rc_q    <= s1_rc_q[RW-1:0];
      s2_rcval_q <= rda_q;
      s2_immw_q  <= s1_immv_q[W-1:0];
      s2_dec_q   <= dec;
    end
    if (ex) begin
      status_q     <= s2_dec_q.status;
      instr_addr_q <= pc_q;
      next_pc_q    <= pc_d;
      cond_code_q  <= cond_d;
      stack_ptr_q  <= sp_d;
      wv_q         <= 32'($signed(wv));
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign instr_addr_o    = instr_addr_q;
  assign next_pc_o       = next_pc_q;
  assign cond_code_o     = cond_code_q;
  assign stack_ptr_o     = stack_ptr_q;
  assign written_value_o = wv_q;

`include "teaching_machine_execute_unit_top_assert.svh"

  `TMEU_ASSERT(a_no_req_while_clearing, !clr_done_q |-> !in_ready_o, "request taken during memory clear")
  `TMEU_ASSERT_NEXT(a_stopped_sticks, stopped_q, stopped_q, "stopped flag cleared")
  `TMEU_ASSERT(a_stages_interlock, s2_v_q |-> !adv, "second stage overrun")

endmodule

>>> design/tmeu_decode.sv
module tmeu_decode
  import tmeu_pkg::*;
(
  input  logic [3:0]           operation_i,
  input  logic                 immediate_flag_i,
  input  logic                 indexed_flag_i,
  input  logic [3:0]           reg_or_cond_i,
  input  logic [3:0]           index_reg_i,
  input  logic [15:0]          offset_i,
  input  logic [9:0]           abs_address_i,
  input  logic [WORD_BITS-1:0] base_i,
  input  logic [PC_W-1:0]      sp_i,
  input  cond_e                cond_i,
  input  logic                 stopped_i,
  input  logic [DS_W-1:0]      data_size_i,
  input  logic [PC_W-1:0]      data_end_i,
  output dec_t                 dec_o
);

  logic [DS_W-1:0] eff;
  logic [EA_W-1:0] ea;
  logic            ea_bad;
  logic            ireg_bad;
  logic            rc_bad;
  status_e         addr_st;
  logic [PC_W-1:0] spp;
  logic            sp_bad;
  logic            spp_bad;
  logic            cond_ok;
  logic            cond_bad;

  always_comb begin
    eff = (data_size_i > DS_W'(DATA_WORDS)) ? DS_W'(DATA_WORDS) : data_size_i;
    if (indexed_flag_i) begin
      ea = {base_i[WORD_BITS-1], base_i} + {{(EA_W-16){offset_i[15]}}, offset_i};
    end else begin
      ea = EA_W'(abs_address_i);
    end
    ea_bad   = ea[EA_W-1] || (ea >= EA_W'(eff));
    ireg_bad = indexed_flag_i && ({1'b0, index_reg_i} >= 5'(NUM_REGS));
    rc_bad   = {1'b0, reg_or_cond_i} >= 5'(NUM_REGS);
    if (ireg_bad) begin
      addr_st = ST_ILLEGAL;
    end else if (ea_bad) begin
      addr_st = ST_DATA;
    end else begin
      addr_st = ST_OK;
    end
    spp     = sp_i + 1'b1;
    sp_bad  = (sp_i < data_end_i) || (DS_W'(sp_i) >= eff);
    spp_bad = (spp < data_end_i) || (DS_W'(spp) >= eff);

    cond_bad = 1'b0;
    cond_ok  = 1'b0;
    if (reg_or_cond_i[3]) begin
      cond_bad = 1'b1;
    end else begin
      unique case (cnd_e'(reg_or_cond_i[2:0]))
        CND_NONE: cond_ok = 1'b1;
        CND_EQ:   cond_ok = (cond_i == CC_ZERO);
        CND_NE:   cond_ok = (cond_i != CC_ZERO);
        CND_GT:   cond_ok = (cond_i == CC_POS);
        CND_GE:   cond_ok = (cond_i == CC_POS) || (cond_i == CC_ZERO);
        CND_LT:   cond_ok = (cond_i == CC_NEG);
        CND_LE:   cond_ok = (cond_i == CC_NEG) || (cond_i == CC_ZERO);
        default:  cond_bad = 1'b1;
      endcase
    end

    dec_o.taken     = 1'b0;
    dec_o.data_addr = ea[AW-1:0];
    dec_o.target    = ea[PC_W-1:0];
    dec_o.rd_addr   = ea[AW-1:0];
    dec_o.status    = ST_OK;

    if (stopped_i) begin
      dec_o.status = ST_STOPPED;
    end else begin
      unique case (operation_i)
        OP_ILLOP: dec_o.status = ST_ILLEGAL;
        OP_NOP:   dec_o.status = ST_OK;
        OP_LOAD, OP_ADD, OP_SUB: begin
          if (rc_bad) begin
            dec_o.status = ST_ILLEGAL;
          end else if (!immediate_flag_i) begin
            dec_o.status = addr_st;
          end
        end
        OP_STORE: begin
          if (immediate_flag_i) begin
            dec_o.status = ST_IMM;
          end else if (rc_bad) begin
            dec_o.status = ST_ILLEGAL;
          end else begin
            dec_o.status = addr_st;
          end
        end
        OP_BRANCH, OP_CALL: begin
          if (immediate_flag_i) begin
            dec_o.status = ST_IMM;
          end else if ((operation_i == OP_CALL) && sp_bad) begin
            dec_o.status = ST_STACK;
          end else if (cond_bad) begin
            dec_o.status = ST_COND;
          end else if (cond_ok) begin
            if (ireg_bad) begin
              dec_o.status = ST_ILLEGAL;
            end else begin
              dec_o.taken = 1'b1;
            end
          end
        end
        OP_RET: begin
          dec_o.rd_addr = spp[AW-1:0];
          if (spp_bad) begin
            dec_o.status = ST_STACK;
          end
        end
        OP_PUSH: begin
          if (sp_bad) begin
            dec_o.status = ST_STACK;
          end else if (!immediate_flag_i) begin
            dec_o.status = addr_st;
          end
        end
        OP_POP: begin
          dec_o.rd_addr = spp[AW-1:0];
          if (immediate_flag_i) begin
            dec_o.status = ST_IMM;
          end else if (addr_st != ST_OK) begin
            dec_o.status = addr_st;
          end else if (spp_bad) begin
            dec_o.status = ST_STACK;
          end
        end
        OP_HALT: dec_o.status = ST_HALT;
        default: dec_o.status = ST_UNKNOWN;
      endcase
    end
  end

endmodule

>>> bench/teaching_machine_execute_unit_top_test.sv
module teaching_machine_execute_unit_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tmeu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [3:0]  op;
    logic        imm_f;
    logic        idx_f;
    logic [3:0]  rc;
    logic [31:0] immv;
    logic [3:0]  ix;
    logic [15:0] off;
    logic [9:0]  abs_a;
  } instr_t;

  typedef struct {
    status_e     status;
    logic [9:0]  instr_addr;
    logic [9:0]  next_pc;
    logic [1:0]  cond_code;
    logic [9:0]  stack_ptr;
    logic [31:0] written_value;
  } outcome_t;

  typedef struct {
    bit          reg_we;
    logic [3:0]  reg_idx;
    logic [31:0] reg_val;
    bit          mem_we;
    logic [9:0]  mem_addr;
    logic [31:0] mem_val;
    logic [9:0]  pc;
    logic [9:0]  sp;
    cond_e       cc;
    bit          stop;
    logic [31:0] wv;
  } change_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [10:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [3:0] operation_i = '0;
  logic immediate_flag_i = 1'b0;
  logic indexed_flag_i = 1'b0;
  logic [3:0] reg_or_cond_i = '0;
  logic [31:0] imm_value_i = '0;
  logic [3:0] index_reg_i = '0;
  logic [15:0] offset_i = '0;
  logic [9:0] abs_address_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [3:0] status_o;
  logic [9:0] instr_addr_o;
  logic [9:0] next_pc_o;
  logic [1:0] cond_code_o;
  logic [9:0] stack_ptr_o;
  logic [31:0] written_value_o;

  teaching_machine_execute_unit_top dut (.*);

  always #10 clk_i = ~clk_i;

  logic [31:0] regs_m [16];
  logic [31:0] mem_m [1024];
  logic [9:0]  pc_m;
  logic [9:0]  sp_m;
  cond_e       cc_m;
  bit          stopped_m;
  int unsigned size_m;
  int unsigned end_m;

  instr_t   pending_instrs[$];
  outcome_t expected_outcomes[$];
  int       errors = 0;
  int       items_sent = 0;
  int       cycle_count = 0;

  function automatic int unsigned eff_size();
    return (size_m > DATA_WORDS) ? DATA_WORDS : size_m;
  endfunction

  function automatic bit sp_bad(logic [9:0] sp);
    return (sp < end_m) || (sp >= eff_size());
  endfunction

  function automatic cond_e sign_of(logic [31:0] v);
    if ($signed(v) < 0) return CC_NEG;
    return (v != 0) ? CC_POS : CC_ZERO;
  endfunction

  function automatic longint operand_addr(instr_t it);
    if (it.idx_f) return longint'($signed(regs_m[it.ix])) + longint'($signed(it.off));
    return longint'(it.abs_a);
  endfunction

  function automatic bit data_ok(instr_t it, output logic [9:0] a);
    longint ea;
    ea = operand_addr(it);
    a = ea[9:0];
    return (ea >= 0) && (ea < longint'(eff_size()));
  endfunction

  function automatic int cond_holds(logic [3:0] c);
    case (c)
      CND_NONE: return 1;
      CND_EQ:   return cc_m == CC_ZERO;
      CND_NE:   return cc_m != CC_ZERO;
      CND_GT:   return cc_m == CC_POS;
      CND_GE:   return cc_m != CC_NEG;
      CND_LT:   return cc_m == CC_NEG;
      CND_LE:   return cc_m != CC_POS;
      default:  return -1;
    endcase
  endfunction

  function automatic status_e run_op(instr_t it, inout change_t u);
    logic [9:0]  a;
    logic [9:0]  spn;
    logic [31:0] src;
    logic [31:0] v;
    longint      ta;
    int          c;
    case (it.op)
      OP_ILLOP: return ST_ILLEGAL;
      OP_NOP:   return ST_OK;
      OP_LOAD, OP_ADD, OP_SUB: begin
        if (it.imm_f) begin
          src = it.immv;
        end else begin
          if (!data_ok(it, a)) return ST_DATA;
          src = mem_m[a];
        end
        if (it.op == OP_LOAD) v = src;
        else if (it.op == OP_ADD) v = regs_m[it.rc] + src;
        else v = regs_m[it.rc] - src;
        u.reg_we = 1; u.reg_idx = it.rc; u.reg_val = v;
        u.cc = sign_of(v); u.wv = v;
        return ST_OK;
      end
      OP_STORE: begin
        if (it.imm_f) return ST_IMM;
        if (!data_ok(it, a)) return ST_DATA;
        u.mem_we = 1; u.mem_addr = a; u.mem_val = regs_m[it.rc]; u.wv = regs_m[it.rc];
        return ST_OK;
      end
      OP_BRANCH, OP_CALL: begin
        if (it.imm_f) return ST_IMM;
        if (it.op == OP_CALL && sp_bad(sp_m)) return ST_STACK;
        c = cond_holds(it.rc);
        if (c < 0) return ST_COND;
        if (c == 0) return ST_OK;
        if (it.op == OP_CALL) begin
          u.mem_we = 1; u.mem_addr = sp_m; u.mem_val = {22'd0, u.pc};
          u.wv = {22'd0, u.pc}; u.sp = sp_m - 10'd1;
        end
        ta = operand_addr(it);
        u.pc = ta[9:0];
        return ST_OK;
      end
      OP_RET: begin
        spn = sp_m + 10'd1;
        if (sp_bad(spn)) return ST_STACK;
        u.sp = spn; u.pc = mem_m[spn][9:0];
        return ST_OK;
      end
      OP_PUSH: begin
        if (sp_bad(sp_m)) return ST_STACK;
        if (it.imm_f) begin
          v = it.immv;
        end else begin
          if (!data_ok(it, a)) return ST_DATA;
          v = mem_m[a];
        end
        u.mem_we = 1; u.mem_addr = sp_m; u.mem_val = v; u.wv = v; u.sp = sp_m - 10'd1;
        return ST_OK;
      end
      OP_POP: begin
        if (it.imm_f) return ST_IMM;
        if (!data_ok(it, a)) return ST_DATA;
        spn = sp_m + 10'd1;
        if (sp_bad(spn)) return ST_STACK;
        u.sp = spn; u.mem_we = 1; u.mem_addr = a; u.mem_val = mem_m[spn]; u.wv = mem_m[spn];
        return ST_OK;
      end
      OP_HALT: return ST_HALT;
      default: return ST_UNKNOWN;
    endcase
  endfunction

  function automatic void predict_outcome(instr_t it, output outcome_t r, output change_t u);
    status_e st;
    u = '{cc: CC_ZERO, default: '0};
    u.cc = cc_m; u.sp = sp_m; u.pc = pc_m + 10'd1;
    if (stopped_m) begin
      st = ST_STOPPED;
      u.pc = pc_m;
    end else begin
      st = run_op(it, u);
      if (st != ST_OK) begin
        u.reg_we = 0; u.mem_we = 0; u.cc = cc_m; u.sp = sp_m; u.wv = '0;
        u.pc = pc_m + 10'd1; u.stop = 1;
      end
    end
    r.status = st; r.instr_addr = pc_m; r.next_pc = u.pc; r.cond_code = u.cc;
    r.stack_ptr = u.sp; r.written_value = u.wv;
  endfunction

  function automatic void commit_change(change_t u);
    if (u.reg_we) regs_m[u.reg_idx] = u.reg_val;
    if (u.mem_we) mem_m[u.mem_addr] = u.mem_val;
    pc_m = u.pc; sp_m = u.sp; cc_m = u.cc;
    if (u.stop) stopped_m = 1;
  endfunction

  function automatic bit queue_instr(instr_t it, bit allow_fault);
    outcome_t r;
    change_t  u;
    predict_outcome(it, r, u);
    if (r.status != ST_OK && !allow_fault) return 0;
    commit_change(u);
    pending_instrs.push_back(it);
    expected_outcomes.push_back(r);
    items_sent++;
    return 1;
  endfunction

  function automatic instr_t mk(logic [3:0] op, logic imf, logic ixf, logic [3:0] rc,
                                logic [31:0] iv, logic [3:0] ix, logic [15:0] off,
                                logic [9:0] ab);
    instr_t it;
    it.op = op; it.imm_f = imf; it.idx_f = ixf; it.rc = rc; it.immv = iv;
    it.ix = ix; it.off = off; it.abs_a = ab;
    return it;
  endfunction

  function automatic instr_t random_instr(bit wild);
    instr_t it;
    it = mk(4'($urandom_range(0, 15)), 1'($urandom), 1'($urandom), 4'($urandom),
            $urandom, 4'($urandom), 16'($urandom), 10'($urandom));
    if (wild) return it;
    it.op = 4'($urandom_range(OP_NOP, OP_POP));
    if (it.op == OP_BRANCH || it.op == OP_CALL) it.rc = 4'($urandom_range(0, 7));
    if ($urandom_range(0, 1)) it.immv = $urandom_range(0, 2100) - 50;
    if ($urandom_range(0, 3) != 0) it.abs_a = 10'($urandom_range(0, eff_size() - 1));
    if ($urandom_range(0, 2) != 0) it.off = 16'($urandom_range(0, 40) - 20);
    if (it.op == OP_STORE || it.op == OP_POP || it.op == OP_BRANCH || it.op == OP_CALL)
      if ($urandom_range(0, 3) != 0) it.imm_f = 0;
    return it;
  endfunction

  task automatic write_reg(int idx, logic [10:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx[0];
    cfg_data_i  <= value;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_DATA_SIZE) size_m = 32'(value);
    else end_m = 32'(value[9:0]);
  endtask

  task automatic drain();
    while (pending_instrs.size() != 0 || expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        void'(pending_instrs.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = cycle_count[11] ? 0 : $urandom_range(0, 6);
        end
      end
      if (in_valid_i && !in_ready_o) begin
      end else if (gap_left == 0 && pending_instrs.size() != 0) begin
        in_valid_i       <= 1'b1;
        operation_i      <= pending_instrs[0].op;
        immediate_flag_i <= pending_instrs[0].imm_f;
        indexed_flag_i   <= pending_instrs[0].idx_f;
        reg_or_cond_i    <= pending_instrs[0].rc;
        imm_value_i      <= pending_instrs[0].immv;
        index_reg_i      <= pending_instrs[0].ix;
        offset_i         <= pending_instrs[0].off;
        abs_address_i    <= pending_instrs[0].abs_a;
      end else begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_outcomes.size() == 0) begin
          $error("result with no pending request: status %0d", status_o);
          errors++;
        end else begin
          e = expected_outcomes.pop_front();
          if (status_o !== e.status) begin
            $error("status expected %0d got %0d", e.status, status_o); errors++;
          end
          if (instr_addr_o !== e.instr_addr) begin
            $error("instr_addr expected %0d got %0d", e.instr_addr, instr_addr_o); errors++;
          end
          if (next_pc_o !== e.next_pc) begin
            $error("next_pc expected %0d got %0d", e.next_pc, next_pc_o); errors++;
          end
          if (cond_code_o !== e.cond_code) begin
            $error("cond_code expected %0d got %0d", e.cond_code, cond_code_o); errors++;
          end
          if (stack_ptr_o !== e.stack_ptr) begin
            $error("stack_ptr expected %0d got %0d", e.stack_ptr, stack_ptr_o); errors++;
          end
          if (written_value_o !== e.written_value) begin
            $error("written_value expected %h got %h", e.written_value, written_value_o);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!cycle_count[10] && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  int unsigned sizes[6] = '{1024, 16, 1024, 1, 512, 1024};
  int unsigned ends[6]  = '{0, 0, 1000, 0, 100, 1023};

  initial begin
    instr_t it;
    int     n;
    bit     ok;
    foreach (regs_m[i]) regs_m[i] = '0;
    foreach (mem_m[i]) mem_m[i] = '0;
    pc_m = '0; sp_m = 10'(DATA_WORDS - 1); cc_m = CC_ZERO; stopped_m = 0;
    size_m = DATA_WORDS; end_m = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    ok = queue_instr(mk(OP_LOAD, 1, 0, 1, 32'h7fffffff, 0, 0, 0), 0);
    ok = queue_instr(mk(OP_LOAD, 1, 1, 2, 32'h80000000, 15, 16'hffff, 10'h3ff), 0);
    ok = queue_instr(mk(OP_ADD, 1, 0, 1, 32'd1, 0, 0, 0), 0);
    ok = queue_instr(mk(OP_SUB, 1, 0, 2, 32'd1, 0, 0, 0), 0);
    ok = queue_instr(mk(OP_LOAD, 1, 0, 3, 32'd0, 0, 0, 0), 0);
    ok = queue_instr(mk(OP_STORE, 0, 0, 1, 0, 0, 0, 10'd1023), 0);
    ok = queue_instr(mk(OP_STORE, 0, 0, 2, 0, 0, 0, 10'd0), 0);
    ok = queue_instr(mk(OP_LOAD, 0, 0, 4, 0, 0, 0, 10'd1023), 0);
    ok = queue_instr(mk(OP_LOAD, 1, 0, 5, 32'd40000, 0, 0, 0), 0);
    ok = queue_instr(mk(OP_STORE, 0, 1, 4, 0, 5, 16'h8000 + 16'd7000, 0), 0);
    ok = queue_instr(mk(OP_LOAD, 0, 1, 6, 0, 3, 16'd1023, 0), 0);
    ok = queue_instr(mk(OP_PUSH, 1, 0, 0, 32'hdeadbeef, 0, 0, 0), 0);
    ok = queue_instr(mk(OP_PUSH, 0, 0, 0, 0, 0, 0, 10'd0), 0);
    ok = queue_instr(mk(OP_POP, 0, 0, 0, 0, 0, 0, 10'd20), 0);
    ok = queue_instr(mk(OP_CALL, 0, 0, CND_NONE, 0, 0, 0, 10'd100), 0);
    ok = queue_instr(mk(OP_NOP, 1, 1, 4'hf, 32'hffffffff, 4'hf, 16'hffff, 10'h3ff), 0);
    ok = queue_instr(mk(OP_RET, 0, 0, 0, 0, 0, 0, 0), 0);
    for (int c = CND_NONE; c <= CND_LE; c++)
      ok = queue_instr(mk(OP_BRANCH, 0, c[0], c[3:0], 0, 3, 16'd300, 10'($urandom)), 0);
    ok = queue_instr(mk(OP_POP, 0, 0, 0, 0, 0, 0, 10'd21), 0);

    foreach (sizes[p]) begin
      drain();
      write_reg(CFG_DATA_SIZE, sizes[p][10:0]);
      write_reg(CFG_DATA_END, ends[p][10:0]);
      for (int k = 0; k < 285; k++) begin
        ok = 0;
        for (int t = 0; t < 30 && !ok; t++) ok = queue_instr(random_instr(0), 0);
        if (!ok) ok = queue_instr(mk(OP_NOP, 1'($urandom), 1'($urandom), 4'($urandom),
                                     $urandom, 4'($urandom), 16'($urandom),
                                     10'($urandom)), 0);
      end
    end

    n = 0;
    while (!stopped_m) begin
      ok = queue_instr(random_instr(1), 1);
      n++;
    end
    repeat (10) ok = queue_instr(random_instr(1), 1);

    drain();
    repeat (20) @(posedge clk_i);
    $display("Ran %0d instructions over %0d memory settings, ending in a stop after %0d",
             items_sent, $size(sizes), n);
    $display("random tries, with %0d mismatches.", errors);
    if (errors == 0 && expected_outcomes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
